FILE: design/cpbm_pkg.sv
// cpbm_pkg: shared constants, opcodes and the result record of the
// column pattern best match block; no dependencies
package cpbm_pkg;

    localparam int ROWS_DEF = 16;
    localparam int COLS_DEF = 8;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 3;
    localparam int MATCH_W  = 4;
    localparam int BESTCOL_W = 4;
    localparam int BESTMIS_W = 5;

    localparam logic [OP_W-1:0] OP_WR_MAT = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_REF = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

    localparam logic signed [BESTCOL_W-1:0] NO_COLUMN = -4'sd1;

    typedef struct packed {
        logic [MATCH_W-1:0]          match_count;
        logic signed [BESTCOL_W-1:0] best_column;
        logic [BESTMIS_W-1:0]        best_mismatches;
    } res_t;

endpackage

FILE: design/column_pattern_best_match.sv
// Column pattern best match. Write beats (matrix or reference element) are
// taken one per cycle while no scan runs. An evaluate beat starts a scan that
// reads one matrix element and its reference element per cycle from the two
// memories, column by column; the read data is registered, and the result
// beat is registered and offered once the last element has been compared.
// item_stall is high during the scan, and an evaluate also waits while the
// previous result beat is still held; writes pass under a held result.
// Reading an element or reference entry that was never written gives an
// undefined result.
// depends on cpbm_pkg, cpbm_store, cpbm_scan
module column_pattern_best_match #(
    parameter int ROWS = cpbm_pkg::ROWS_DEF,
    parameter int COLS = cpbm_pkg::COLS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [cpbm_pkg::OP_W-1:0]            op,
    input  logic [cpbm_pkg::ROW_W-1:0]           row,
    input  logic [cpbm_pkg::COL_W-1:0]           col,
    input  logic signed [cpbm_pkg::DATA_W-1:0]   value,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [cpbm_pkg::MATCH_W-1:0]         match_count,
    output logic signed [cpbm_pkg::BESTCOL_W-1:0] best_column,
    output logic [cpbm_pkg::BESTMIS_W-1:0]       best_mismatches
);
    import cpbm_pkg::*;

    localparam int AW = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic          accept;
    logic          start;
    logic          busy;
    logic          rd_en;
    logic [AW-1:0] rd_mat_addr;
    logic [RW-1:0] rd_ref_addr;
    logic [DATA_W-1:0] mat_q;
    logic [DATA_W-1:0] ref_q;
    logic          done;
    res_t          scan_res;

    logic          result_valid_reg;
    res_t          result_reg;

    assign item_stall = busy || (result_valid_reg && (op == OP_EVAL));
    assign accept     = item_valid && !item_stall;
    assign start      = accept && (op == OP_EVAL);

    cpbm_store #(
        .ROWS (ROWS),
        .COLS (COLS),
        .AW   (AW),
        .RW   (RW)
    ) u_store (
        .clk         (clk),
        .wr_en       (accept),
        .op          (op),
        .row         (row),
        .col         (col),
        .value       (value),
        .rd_en       (rd_en),
        .rd_mat_addr (rd_mat_addr),
        .rd_ref_addr (rd_ref_addr),
        .mat_q       (mat_q),
        .ref_q       (ref_q)
    );

    cpbm_scan #(
        .ROWS (ROWS),
        .COLS (COLS),
        .AW   (AW),
        .RW   (RW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .rd_en       (rd_en),
        .rd_mat_addr (rd_mat_addr),
        .rd_ref_addr (rd_ref_addr),
        .mat_q       (mat_q),
        .ref_q       (ref_q),
        .done        (done),
        .result      (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            result_reg <= scan_res;
        end
    end

    assign result_valid    = result_valid_reg;
    assign match_count     = result_reg.match_count;
    assign best_column     = result_reg.best_column;
    assign best_mismatches = result_reg.best_mismatches;

    // a finished scan never lands on a result beat still waiting
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !result_valid_reg)
        else $error("scan finished over a held result");

    // an accepted evaluate starts the scan on the next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("evaluate did not start a scan");

    // nothing is taken while the scan runs
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept)
        else $error("beat accepted during scan");

    // an exact match makes the best mismatch count zero
    a_match_best: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (scan_res.match_count != '0)) |-> (scan_res.best_mismatches == '0))
        else $error("exact match without zero best mismatch count");

endmodule

FILE: design/cpbm_store.sv
// cpbm_store: matrix memory and reference memory, one write port each
// and one registered read port each; depends on cpbm_pkg
module cpbm_store #(
    parameter int ROWS = cpbm_pkg::ROWS_DEF,
    parameter int COLS = cpbm_pkg::COLS_DEF,
    parameter int AW   = 1,
    parameter int RW   = 1
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [cpbm_pkg::OP_W-1:0]     op,
    input  logic [cpbm_pkg::ROW_W-1:0]    row,
    input  logic [cpbm_pkg::COL_W-1:0]    col,
    input  logic [cpbm_pkg::DATA_W-1:0]   value,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_mat_addr,
    input  logic [RW-1:0]                 rd_ref_addr,
    output logic [cpbm_pkg::DATA_W-1:0]   mat_q,
    output logic [cpbm_pkg::DATA_W-1:0]   ref_q
);
    import cpbm_pkg::*;

    logic [DATA_W-1:0] mat_mem [ROWS*COLS];
    logic [DATA_W-1:0] ref_mem [ROWS];

    logic          row_ok;
    logic          col_ok;
    logic          mat_we;
    logic          ref_we;
    logic [AW-1:0] wr_mat_addr;
    logic [RW-1:0] wr_ref_addr;
    logic [DATA_W-1:0] mat_q_reg;
    logic [DATA_W-1:0] ref_q_reg;

    always_comb
    begin
        row_ok      = int'(row) < ROWS;
        col_ok      = int'(col) < COLS;
        mat_we      = wr_en && (op == OP_WR_MAT) && row_ok && col_ok;
        ref_we      = wr_en && (op == OP_WR_REF) && row_ok;
        wr_mat_addr = AW'(int'(row) * COLS + int'(col));
        wr_ref_addr = RW'(row);
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[wr_mat_addr] <= value;
        end
        if (ref_we)
        begin
            ref_mem[wr_ref_addr] <= value;
        end
        if (rd_en)
        begin
            mat_q_reg <= mat_mem[rd_mat_addr];
            ref_q_reg <= ref_mem[rd_ref_addr];
        end
    end

    assign mat_q = mat_q_reg;
    assign ref_q = ref_q_reg;

endmodule

FILE: design/cpbm_scan.sv
// cpbm_scan: walks the matrix column by column, compares each element with
// the reference and keeps match and best column tallies; depends on cpbm_pkg
module cpbm_scan #(
    parameter int ROWS = cpbm_pkg::ROWS_DEF,
    parameter int COLS = cpbm_pkg::COLS_DEF,
    parameter int AW   = 1,
    parameter int RW   = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_mat_addr,
    output logic [RW-1:0]                rd_ref_addr,
    input  logic [cpbm_pkg::DATA_W-1:0]  mat_q,
    input  logic [cpbm_pkg::DATA_W-1:0]  ref_q,
    output logic                         done,
    output cpbm_pkg::res_t               result
);
    import cpbm_pkg::*;

    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int MW = $clog2(ROWS + 1);
    localparam int NW = $clog2(COLS + 1);

    // issue side
    logic          issue_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [AW-1:0] addr_reg;
    logic          last_row;
    logic          last_col;

    // tags that travel with the read data
    logic          rd_valid_reg;
    logic          rd_first_reg;
    logic          rd_last_row_reg;
    logic          rd_last_col_reg;
    logic [CW-1:0] rd_col_reg;

    // tallies
    logic [MW-1:0] miss_reg;
    logic [NW-1:0] matches_reg;
    logic [MW-1:0] best_cnt_reg;
    logic [CW-1:0] best_col_reg;
    logic          found_reg;

    logic          neq;
    logic [MW-1:0] col_miss;
    logic          better;
    logic [NW-1:0] matches_upd;
    logic [MW-1:0] best_cnt_upd;
    logic [CW-1:0] best_col_upd;
    logic          found_upd;
    logic          col_end;

    assign last_row    = row_reg == RW'(ROWS - 1);
    assign last_col    = col_reg == CW'(COLS - 1);
    assign rd_en       = issue_reg;
    assign rd_mat_addr = addr_reg;
    assign rd_ref_addr = row_reg;
    assign busy        = issue_reg || rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && last_row && last_col)
            begin
                issue_reg <= 1'b0;
            end
            rd_valid_reg <= issue_reg;
        end
    end

    // address walk: down a column by COLS, then over to the next column head
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            addr_reg <= '0;
        end
        else if (issue_reg)
        begin
            if (last_row)
            begin
                row_reg  <= '0;
                col_reg  <= col_reg + CW'(1);
                addr_reg <= AW'(col_reg) + AW'(1);
            end
            else
            begin
                row_reg  <= row_reg + RW'(1);
                addr_reg <= addr_reg + AW'(COLS);
            end
        end
        rd_first_reg    <= row_reg == '0;
        rd_last_row_reg <= last_row;
        rd_last_col_reg <= last_col;
        rd_col_reg      <= col_reg;
    end

    always_comb
    begin
        neq          = mat_q != ref_q;
        col_miss     = (rd_first_reg ? '0 : miss_reg) + MW'(neq);
        better       = col_miss < best_cnt_reg;
        matches_upd  = matches_reg + NW'(col_miss == '0);
        best_cnt_upd = better ? col_miss : best_cnt_reg;
        best_col_upd = better ? rd_col_reg : best_col_reg;
        found_upd    = better || found_reg;
        col_end      = rd_valid_reg && rd_last_row_reg;
        done         = col_end && rd_last_col_reg;

        result.match_count     = MATCH_W'(matches_upd);
        result.best_column     = found_upd ? BESTCOL_W'(best_col_upd) : NO_COLUMN;
        result.best_mismatches = BESTMIS_W'(best_cnt_upd);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            matches_reg  <= '0;
            best_cnt_reg <= MW'(ROWS);
            best_col_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (col_end)
        begin
            matches_reg  <= matches_upd;
            best_cnt_reg <= best_cnt_upd;
            best_col_reg <= best_col_upd;
            found_reg    <= found_upd;
        end
        if (rd_valid_reg)
        begin
            miss_reg <= col_miss;
        end
    end

endmodule

FILE: tb/testbench.sv
// testbench for column_pattern_best_match: loads the matrix and the reference
// column, runs evaluates and scores every result beat against a pinned score or a local model
// depends on cpbm_pkg and the column_pattern_best_match rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cpbm_pkg::*;

    localparam int ROWS = ROWS_DEF;
    localparam int COLS = COLS_DEF;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLDOFF_CYCLES = 600;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic [DATA_W-1:0]        value;
        logic                     pinned;
        res_t                     score;
    } stim_row_t;

    localparam res_t NO_SCORE = '0;

    // opening rows: after the load every matrix entry is zero and the
    // reference column is zero, so all eight columns match
    localparam stim_row_t DIRECTED [18] = '{
        '{OP_EVAL,   4'd15, 3'd7, 32'hFFFF_FFFF, 1'b1, '{4'd8, 4'sd0, 5'd0}},
        '{OP_UNUSED, 4'd3,  3'd4, 32'hFFFF_FFFF, 1'b0, NO_SCORE},
        '{OP_WR_MAT, 4'd0,  3'd0, 32'h8000_0000, 1'b0, NO_SCORE},
        '{OP_WR_MAT, 4'd15, 3'd0, 32'h7FFF_FFFF, 1'b0, NO_SCORE},
        '{OP_EVAL,   4'd0,  3'd0, 32'h0000_0000, 1'b1, '{4'd7, 4'sd1, 5'd0}},
        '{OP_WR_REF, 4'd0,  3'd5, 32'h8000_0000, 1'b0, NO_SCORE},
        '{OP_WR_REF, 4'd15, 3'd2, 32'h7FFF_FFFF, 1'b0, NO_SCORE},
        '{OP_EVAL,   4'd9,  3'd6, 32'h1234_5678, 1'b1, '{4'd1, 4'sd0, 5'd0}},
        '{OP_WR_MAT, 4'd0,  3'd7, 32'h8000_0000, 1'b0, NO_SCORE},
        '{OP_WR_MAT, 4'd15, 3'd7, 32'h7FFF_FFFF, 1'b0, NO_SCORE},
        '{OP_WR_MAT, 4'd7,  3'd0, 32'hFFFF_FFFF, 1'b0, NO_SCORE},
        '{OP_EVAL,   4'd5,  3'd1, 32'hA5A5_A5A5, 1'b0, NO_SCORE},
        '{OP_WR_MAT, 4'd7,  3'd7, 32'h0000_0001, 1'b0, NO_SCORE},
        '{OP_EVAL,   4'd12, 3'd3, 32'h5A5A_5A5A, 1'b0, NO_SCORE},
        '{OP_WR_REF, 4'd7,  3'd7, 32'hFFFF_FFFF, 1'b0, NO_SCORE},
        '{OP_EVAL,   4'd1,  3'd2, 32'h0000_0000, 1'b0, NO_SCORE},
        '{OP_UNUSED, 4'd7,  3'd0, 32'h0000_0000, 1'b0, NO_SCORE},
        '{OP_EVAL,   4'd0,  3'd0, 32'hFFFF_FFFF, 1'b0, NO_SCORE}
    };

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_stall;
    logic [OP_W-1:0]              op;
    logic [ROW_W-1:0]             row;
    logic [COL_W-1:0]             col;
    logic signed [DATA_W-1:0]     value;
    logic                         result_valid;
    logic                         result_stall;
    logic [MATCH_W-1:0]           match_count;
    logic signed [BESTCOL_W-1:0]  best_column;
    logic [BESTMIS_W-1:0]         best_mismatches;

    logic [DATA_W-1:0] matrix_img [ROWS][COLS];
    logic [DATA_W-1:0] reference_img [ROWS];
    res_t              awaited_scores [$];
    int                fault_count = 0;
    int                item_count = 0;
    bit                idling = 1'b1;
    bit                holdoff_req = 1'b0;

    column_pattern_best_match #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .op              (op),
        .row             (row),
        .col             (col),
        .value           (value),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .match_count     (match_count),
        .best_column     (best_column),
        .best_mismatches (best_mismatches)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // small pool so that equal words, and so matching columns, are common
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4, 5: return $urandom;
            default: return DATA_W'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic res_t score_columns();
        res_t s;
        int   hits;
        int   best_miss;
        int   best_idx;
        int   miss;
        hits = 0;
        best_miss = ROWS;
        best_idx = -1;
        for (int c = 0; c < COLS; c++)
        begin
            miss = 0;
            for (int r = 0; r < ROWS; r++)
                if (matrix_img[r][c] != reference_img[r])
                    miss++;
            if (miss == 0)
                hits++;
            if (miss < best_miss)
            begin
                best_miss = miss;
                best_idx = c;
            end
        end
        s.match_count = MATCH_W'(hits);
        s.best_column = (best_idx < 0) ? NO_COLUMN : BESTCOL_W'(best_idx);
        s.best_mismatches = BESTMIS_W'(best_miss);
        return s;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input logic [OP_W-1:0] beat_op,
                             input logic [ROW_W-1:0] beat_row,
                             input logic [COL_W-1:0] beat_col,
                             input logic [DATA_W-1:0] beat_value,
                             input bit pinned = 1'b0,
                             input res_t pinned_score = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        op = beat_op;
        row = beat_row;
        col = beat_col;
        value = beat_value;
        do
            @(posedge clk);
        while (item_stall);
        case (beat_op)
            OP_WR_MAT: matrix_img[beat_row][beat_col] = beat_value;
            OP_WR_REF: reference_img[beat_row] = beat_value;
            OP_EVAL:   awaited_scores.push_back(pinned ? pinned_score : score_columns());
            default: ;
        endcase
        if (beat_op != OP_UNUSED)
            item_count++;
        @(negedge clk);
    endtask

    task automatic send_eval();
        send_beat(OP_EVAL, ROW_W'($urandom), COL_W'($urandom), $urandom);
    endtask

    task automatic wait_for_results();
        item_valid = 1'b0;
        while (awaited_scores.size() != 0)
            @(negedge clk);
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                stall_left = HOLDOFF_CYCLES;
            end
            else if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                result_stall = 1'b1;
                stall_left--;
            end
            else
                result_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin : score_check
        res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_scores.size() == 0)
            begin
                $display("%0t: result beat with none awaited: %0d %0d %0d", $time,
                         match_count, best_column, best_mismatches);
                fault_count++;
            end
            else
            begin
                want = awaited_scores.pop_front();
                if (match_count !== want.match_count)
                begin
                    $display("%0t: match_count expected %0d actual %0d", $time,
                             want.match_count, match_count);
                    fault_count++;
                end
                if (best_column !== want.best_column)
                begin
                    $display("%0t: best_column expected %0d actual %0d", $time,
                             want.best_column, best_column);
                    fault_count++;
                end
                if (best_mismatches !== want.best_mismatches)
                begin
                    $display("%0t: best_mismatches expected %0d actual %0d", $time,
                             want.best_mismatches, best_mismatches);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int kind;
        int n;
        int c;
        int dev;
        logic [DATA_W-1:0] v;

        rst_n = 1'b0;
        item_valid = 1'b0;
        op = OP_WR_MAT;
        row = '0;
        col = '0;
        value = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // load everything before the first evaluate; the reference differs
        // from every matrix word, so no column qualifies
        for (int r = 0; r < ROWS; r++)
            for (int k = 0; k < COLS; k++)
                send_beat(OP_WR_MAT, ROW_W'(r), COL_W'(k), 32'h0000_0000);
        for (int r = 0; r < ROWS; r++)
            send_beat(OP_WR_REF, ROW_W'(r), COL_W'($urandom), 32'h5555_5555);
        send_beat(OP_EVAL, 4'd0, 3'd0, 32'h0, 1'b1,
                  '{4'd0, NO_COLUMN, 5'(ROWS)});
        for (int r = 0; r < ROWS; r++)
            send_beat(OP_WR_REF, ROW_W'(r), COL_W'($urandom), 32'h0000_0000);

        foreach (DIRECTED[i])
            send_beat(DIRECTED[i].op, DIRECTED[i].row, DIRECTED[i].col,
                      DIRECTED[i].value, DIRECTED[i].pinned, DIRECTED[i].score);

        // the receiver holds off while evaluates keep coming, so the held
        // result blocks the next evaluate
        wait_for_results();
        holdoff_req = 1'b1;
        send_eval();
        send_beat(OP_WR_MAT, ROW_W'($urandom), COL_W'($urandom), pick_value());
        send_eval();
        send_beat(OP_WR_REF, ROW_W'($urandom), COL_W'($urandom), pick_value());
        send_eval();
        wait_for_results();

        item_count = 0;
        while (item_count < RANDOM_ITEMS)
        begin
            idling = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                // copy the reference into one column with a few deviations
                c = $urandom_range(0, COLS - 1);
                dev = $urandom_range(0, 3);
                for (int r = 0; r < ROWS; r++)
                begin
                    v = reference_img[r];
                    if ($urandom_range(0, 15) < dev)
                        v = pick_value();
                    send_beat(OP_WR_MAT, ROW_W'(r), COL_W'(c), v);
                end
                send_eval();
            end
            else if (kind < 7)
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    case ($urandom_range(0, 19))
                        0: send_beat(OP_UNUSED, ROW_W'($urandom), COL_W'($urandom),
                                     $urandom);
                        1, 2, 3: send_beat(OP_WR_REF, ROW_W'($urandom), COL_W'($urandom),
                                           pick_value());
                        default: send_beat(OP_WR_MAT, ROW_W'($urandom), COL_W'($urandom),
                                           pick_value());
                    endcase
                end
                send_eval();
            end
            else if (kind < 9)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_beat(OP_WR_REF, ROW_W'($urandom), COL_W'($urandom), pick_value());
                send_eval();
            end
            else
            begin
                // broken copy: a column only partly rewritten, then noise
                c = $urandom_range(0, COLS - 1);
                n = $urandom_range(1, ROWS - 1);
                for (int r = 0; r < n; r++)
                    send_beat(OP_WR_MAT, ROW_W'(r), COL_W'(c), reference_img[r]);
                send_beat(OP_UNUSED, ROW_W'($urandom), COL_W'($urandom), $urandom);
                send_eval();
                send_eval();
            end
        end

        idling = 1'b1;
        wait_for_results();
        repeat (ROWS * COLS + 50) @(posedge clk);
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
